// File: hdl/ihq_pkg.sv
`timescale 1ns / 1ps
package ihq_pkg;

    localparam int CAPACITY = 64;
    localparam int HANDLES  = 256;
    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 8;
    localparam int SLOT_W   = 7;   // holds 0..CAPACITY
    localparam int ADDR_W   = 6;   // slot index into storage
    localparam int FUNC_W   = 2;
    localparam int STAT_W   = 2;

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_SETKEY = 2'd2;
    localparam logic [FUNC_W-1:0] FN_LOCATE = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_SLOT = 2'd2;
    localparam logic [STAT_W-1:0] ST_SAME_KEY = 2'd3;

    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
    } t_slot_wr;

    typedef struct packed {
        logic                en;
        logic [HANDLE_W-1:0] handle;
        logic [SLOT_W-1:0]   pos;
    } t_pos_wr;

endpackage

// File: hdl/ihq_slot_ram.sv
`timescale 1ns / 1ps
module ihq_slot_ram (
    input  logic                     i_clk,
    input  ihq_pkg::t_slot_wr        i_wr,
    input  logic [ihq_pkg::ADDR_W-1:0]   i_rd_addr,
    output logic [ihq_pkg::HANDLE_W-1:0] o_rd_handle,
    output logic [ihq_pkg::KEY_W-1:0]    o_rd_key
);
    import ihq_pkg::*;

    logic [HANDLE_W-1:0] r_handle_mem [CAPACITY];
    logic [KEY_W-1:0]    r_key_mem    [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_handle_mem[i_wr.addr] <= i_wr.handle;
            r_key_mem[i_wr.addr]    <= i_wr.key;
        end
        o_rd_handle <= r_handle_mem[i_rd_addr];
        o_rd_key    <= r_key_mem[i_rd_addr];
    end

endmodule

// File: hdl/ihq_pos_ram.sv
`timescale 1ns / 1ps
module ihq_pos_ram (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ihq_pkg::t_pos_wr             i_wr,
    input  logic [ihq_pkg::HANDLE_W-1:0] i_rd_handle,
    output logic [ihq_pkg::SLOT_W-1:0]   o_rd_pos
);
    import ihq_pkg::*;

    logic [SLOT_W-1:0] r_mem [HANDLES];
    logic [HANDLES-1:0] r_valid;   // unwritten entries read as absent

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.handle] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.handle] <= i_wr.pos;
        end
        o_rd_pos <= r_valid[i_rd_handle] ? r_mem[i_rd_handle] : '0;
    end

endmodule

// File: hdl/indexed_max_heap_queue.sv
`timescale 1ns / 1ps
// Channel | direction | handshake          | beat payload
// in      | sink      | i_valid / o_stall  | i_func, i_handle, i_key, i_slot
// out     | source    | o_valid / i_stall  | o_status, o_out_handle, o_out_key, o_out_slot,
//         |           |                    | o_head_valid, o_head_handle, o_head_key, o_count
//
// One operation at a time; o_stall is high from acceptance until the result beat leaves.
// Errors go straight to the result; locate reads the position map. Insert/delete/set key:
// set-up, then UP/UPC per level climbed and DN/DNL/DNR/DNC per level descended (single read
// port of the slot store, one key comparator), then PLACE; DNR only with a right child.
// Synchronous active-low reset empties the heap; position map valid bits clear at once.
// The result beat is held in registers and stays steady while i_stall is high.
module indexed_max_heap_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [ihq_pkg::FUNC_W-1:0]   i_func,
    input  logic [ihq_pkg::HANDLE_W-1:0] i_handle,
    input  logic [ihq_pkg::KEY_W-1:0]    i_key,
    input  logic [ihq_pkg::SLOT_W-1:0]   i_slot,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [ihq_pkg::STAT_W-1:0]   o_status,
    output logic [ihq_pkg::HANDLE_W-1:0] o_out_handle,
    output logic [ihq_pkg::KEY_W-1:0]    o_out_key,
    output logic [ihq_pkg::SLOT_W-1:0]   o_out_slot,
    output logic                         o_head_valid,
    output logic [ihq_pkg::HANDLE_W-1:0] o_head_handle,
    output logic [ihq_pkg::KEY_W-1:0]    o_head_key,
    output logic [ihq_pkg::SLOT_W-1:0]   o_count
);
    import ihq_pkg::*;

    // Sequencer states: entry, sift up (UP/UPC), sift down (DN/DNL/DNR/DNC), place, result.
    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_LOC   = 13'b0000000000010,
        S_DEL1  = 13'b0000000000100,
        S_DEL2  = 13'b0000000001000,
        S_SK1   = 13'b0000000010000,
        S_UP    = 13'b0000000100000,
        S_UPC   = 13'b0000001000000,
        S_DN    = 13'b0000010000000,
        S_DNL   = 13'b0000100000000,
        S_DNR   = 13'b0001000000000,
        S_DNC   = 13'b0010000000000,
        S_PLACE = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    localparam logic [SLOT_W-1:0] SLOT_ONE = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] CAP_S    = SLOT_W'(CAPACITY);

    t_state r_state, n_state;

    // Working registers
    logic [HANDLE_W-1:0] r_h;      // entry being placed
    logic [KEY_W-1:0]    r_k;
    logic [SLOT_W-1:0]   r_i;      // hole position
    logic [SLOT_W-1:0]   r_s;      // requested slot
    logic [SLOT_W-1:0]   r_b;      // chosen child
    logic [HANDLE_W-1:0] r_ch;
    logic [KEY_W-1:0]    r_ck;
    logic [SLOT_W-1:0]   r_cnt;
    logic [HANDLE_W-1:0] r_head_h;
    logic [KEY_W-1:0]    r_head_k;
    // Result registers
    logic [STAT_W-1:0]   r_status;
    logic [HANDLE_W-1:0] r_oh;
    logic [KEY_W-1:0]    r_ok;
    logic [SLOT_W-1:0]   r_os;

    t_slot_wr            slot_wr;
    t_pos_wr             pos_wr;
    logic [ADDR_W-1:0]   rd_addr;
    logic [HANDLE_W-1:0] rd_h;
    logic [KEY_W-1:0]    rd_k;
    logic [SLOT_W-1:0]   rd_pos;

    // Shared key comparator
    logic [KEY_W-1:0] cmp_a, cmp_b;
    logic             cmp_gt, cmp_eq;

    logic              accept;
    logic [SLOT_W:0]   left;       // 2*i, one bit wider
    logic [SLOT_W-1:0] parent;
    logic              bad_slot;

    assign accept   = (r_state == S_IDLE) && i_valid;
    assign left     = {r_i, 1'b0};
    assign parent   = r_i >> 1;
    assign bad_slot = (i_slot == '0) || (i_slot > r_cnt);
    assign cmp_gt   = cmp_a > cmp_b;
    assign cmp_eq   = cmp_a == cmp_b;

    ihq_slot_ram u_slot (
        .i_clk      (i_clk),
        .i_wr       (slot_wr),
        .i_rd_addr  (rd_addr),
        .o_rd_handle(rd_h),
        .o_rd_key   (rd_k)
    );

    ihq_pos_ram u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (pos_wr),
        .i_rd_handle(i_handle),
        .o_rd_pos   (rd_pos)
    );

    always_comb begin
        cmp_a = r_k;
        cmp_b = r_k;
        case (r_state)
            S_SK1:   begin cmp_a = rd_k; cmp_b = r_k;  end
            S_UPC:   begin cmp_a = r_k;  cmp_b = rd_k; end
            S_DNR:   begin cmp_a = r_ck; cmp_b = rd_k; end  // left > right keeps left
            S_DNC:   begin cmp_a = r_ck; cmp_b = r_k;  end
            default: begin cmp_a = r_k;  cmp_b = r_k;  end
        endcase
    end

    always_comb begin
        n_state = r_state;
        rd_addr = '0;
        slot_wr = '0;
        pos_wr  = '0;
        case (r_state)
            S_IDLE: begin
                rd_addr = ADDR_W'(i_slot - SLOT_ONE);
                if (i_valid) begin
                    case (i_func)
                        FN_INSERT: n_state = (r_cnt >= CAP_S) ? S_DONE : S_UP;
                        FN_DELETE: n_state = bad_slot ? S_DONE : S_DEL1;
                        FN_SETKEY: n_state = bad_slot ? S_DONE : S_SK1;
                        default:   n_state = S_LOC;
                    endcase
                end
            end
            S_LOC: n_state = S_DONE;
            S_DEL1: begin
                pos_wr  = '{en: 1'b1, handle: rd_h, pos: '0};
                rd_addr = ADDR_W'(r_cnt - SLOT_ONE);
                n_state = (r_s == r_cnt) ? S_DONE : S_DEL2;
            end
            S_DEL2: n_state = S_UP;
            S_SK1:  n_state = cmp_eq ? S_DONE : S_UP;
            S_UP: begin
                rd_addr = ADDR_W'(parent - SLOT_ONE);
                n_state = (r_i > SLOT_ONE) ? S_UPC : S_DN;
            end
            S_UPC: begin
                if (cmp_gt) begin
                    slot_wr = '{en: 1'b1, addr: ADDR_W'(r_i - SLOT_ONE), handle: rd_h, key: rd_k};
                    pos_wr  = '{en: 1'b1, handle: rd_h, pos: r_i};
                    n_state = S_UP;
                end else begin
                    n_state = S_DN;
                end
            end
            S_DN: begin
                rd_addr = ADDR_W'(left - 1'b1);
                n_state = (left > {1'b0, r_cnt}) ? S_PLACE : S_DNL;
            end
            S_DNL: begin
                rd_addr = r_b[ADDR_W-1:0];   // right child
                n_state = (r_b < r_cnt) ? S_DNR : S_DNC;
            end
            S_DNR: n_state = S_DNC;
            S_DNC: begin
                if (cmp_gt) begin
                    slot_wr = '{en: 1'b1, addr: ADDR_W'(r_i - SLOT_ONE), handle: r_ch, key: r_ck};
                    pos_wr  = '{en: 1'b1, handle: r_ch, pos: r_i};
                    n_state = S_DN;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                slot_wr = '{en: 1'b1, addr: ADDR_W'(r_i - SLOT_ONE), handle: r_h, key: r_k};
                pos_wr  = '{en: 1'b1, handle: r_h, pos: r_i};
                n_state = S_DONE;
            end
            S_DONE:  n_state = i_stall ? S_DONE : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_status <= ST_OK;
        end else begin
            r_state <= n_state;
            if (slot_wr.en && slot_wr.addr == '0) begin
                r_head_h <= slot_wr.handle;
                r_head_k <= slot_wr.key;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_h      <= i_handle;
                        r_k      <= i_key;
                        r_s      <= i_slot;
                        r_status <= ST_OK;
                        r_oh     <= '0;
                        r_ok     <= '0;
                        r_os     <= '0;
                        case (i_func)
                            FN_INSERT: begin
                                if (r_cnt >= CAP_S) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_cnt <= r_cnt + SLOT_ONE;
                                    r_i   <= r_cnt + SLOT_ONE;
                                end
                            end
                            FN_DELETE, FN_SETKEY: begin
                                if (bad_slot) r_status <= ST_BAD_SLOT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_LOC: r_os <= rd_pos;
                S_DEL1: begin
                    r_oh  <= rd_h;
                    r_ok  <= rd_k;
                    r_cnt <= r_cnt - SLOT_ONE;
                end
                S_DEL2: begin
                    r_h <= rd_h;
                    r_k <= rd_k;
                    r_i <= r_s;
                end
                S_SK1: begin
                    if (cmp_eq) begin
                        r_status <= ST_SAME_KEY;
                        r_os     <= r_s;
                    end else begin
                        r_h <= rd_h;
                        r_i <= r_s;
                    end
                end
                S_UPC: if (cmp_gt) r_i <= parent;
                S_DN:  r_b <= left[SLOT_W-1:0];
                S_DNL: begin
                    r_ch <= rd_h;
                    r_ck <= rd_k;
                end
                S_DNR: begin
                    if (!cmp_gt) begin      // right wins ties
                        r_ch <= rd_h;
                        r_ck <= rd_k;
                        r_b  <= r_b + SLOT_ONE;
                    end
                end
                S_DNC:   if (cmp_gt) r_i <= r_b;
                S_PLACE: r_os <= r_i;
                default: ;
            endcase
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_DONE);
    assign o_status      = r_status;
    assign o_out_handle  = r_oh;
    assign o_out_key     = r_ok;
    assign o_out_slot    = r_os;
    assign o_count       = r_cnt;
    assign o_head_valid  = (r_cnt != '0);
    assign o_head_handle = (r_cnt != '0) ? r_head_h : '0;
    assign o_head_key    = (r_cnt != '0) ? r_head_k : '0;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP_S) else $error("entry count above capacity");

    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_func == FN_INSERT && r_cnt >= CAP_S)
        |=> (r_status == ST_FULL && r_state == S_DONE && $stable(r_cnt)))
        else $error("insert on full heap not rejected");

    a_hole_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP || r_state == S_DN || r_state == S_PLACE) |-> (r_i != '0))
        else $error("sift hole at slot zero");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        slot_wr.en |-> (r_i <= r_cnt)) else $error("slot write beyond count");

endmodule

// File: tb/indexed_max_heap_queue_tb.sv
`timescale 1ns / 1ps
module indexed_max_heap_queue_tb;
    import ihq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_RANDOM = 670;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
        logic [SLOT_W-1:0]   slot;
        logic                drain;   // hold off until every result is back
    } t_op;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [HANDLE_W-1:0] out_handle;
        logic [KEY_W-1:0]    out_key;
        logic [SLOT_W-1:0]   out_slot;
        logic                head_valid;
        logic [HANDLE_W-1:0] head_handle;
        logic [KEY_W-1:0]    head_key;
        logic [SLOT_W-1:0]   count;
    } t_res;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [FUNC_W-1:0]   i_func = FN_LOCATE;
    logic [HANDLE_W-1:0] i_handle = '0;
    logic [KEY_W-1:0]    i_key = '0;
    logic [SLOT_W-1:0]   i_slot = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [STAT_W-1:0]   o_status;
    logic [HANDLE_W-1:0] o_out_handle;
    logic [KEY_W-1:0]    o_out_key;
    logic [SLOT_W-1:0]   o_out_slot;
    logic                o_head_valid;
    logic [HANDLE_W-1:0] o_head_handle;
    logic [KEY_W-1:0]    o_head_key;
    logic [SLOT_W-1:0]   o_count;

    indexed_max_heap_queue dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---- mirror of the heap ------------------------------------------------
    logic [HANDLE_W-1:0] hp_handle [1:CAPACITY];
    logic [KEY_W-1:0]    hp_key    [1:CAPACITY];
    logic [SLOT_W-1:0]   hp_pos    [HANDLES];
    int                  hp_count;

    t_op  pending_ops[$];
    t_res expected_res[$];
    bit   failed = 1'b0;

    function automatic void hp_move(int dst, int src);
        hp_handle[dst] = hp_handle[src];
        hp_key[dst]    = hp_key[src];
        hp_pos[hp_handle[dst]] = SLOT_W'(dst);
    endfunction

    // Place an entry at slot i: climb past strictly smaller parents, then
    // fall past strictly larger children (right child wins a tie).
    function automatic int hp_settle(int i, logic [HANDLE_W-1:0] h, logic [KEY_W-1:0] k);
        int c;
        while (i > 1 && k > hp_key[i / 2]) begin
            hp_move(i, i / 2);
            i = i / 2;
        end
        forever begin
            if (2 * i > hp_count) break;
            c = 2 * i;
            if (c + 1 <= hp_count && hp_key[c + 1] >= hp_key[c]) c = c + 1;
            if (!(hp_key[c] > k)) break;
            hp_move(i, c);
            i = c;
        end
        hp_handle[i] = h;
        hp_key[i]    = k;
        hp_pos[h]    = SLOT_W'(i);
        return i;
    endfunction

    function automatic t_res hp_apply(t_op op);
        t_res r;
        int   s;
        r = '0;
        s = op.slot;
        case (op.func)
            FN_INSERT: begin
                if (hp_count >= CAPACITY) r.status = ST_FULL;
                else begin
                    hp_count++;
                    r.out_slot = SLOT_W'(hp_settle(hp_count, op.handle, op.key));
                end
            end
            FN_DELETE: begin
                if (s == 0 || s > hp_count) r.status = ST_BAD_SLOT;
                else begin
                    r.out_handle = hp_handle[s];
                    r.out_key    = hp_key[s];
                    hp_pos[hp_handle[s]] = '0;
                    hp_count--;
                    if (s != hp_count + 1)
                        r.out_slot = SLOT_W'(hp_settle(s, hp_handle[hp_count + 1],
                                                       hp_key[hp_count + 1]));
                end
            end
            FN_SETKEY: begin
                if (s == 0 || s > hp_count) r.status = ST_BAD_SLOT;
                else if (hp_key[s] == op.key) begin
                    r.status   = ST_SAME_KEY;
                    r.out_slot = op.slot;
                end else r.out_slot = SLOT_W'(hp_settle(s, hp_handle[s], op.key));
            end
            default: r.out_slot = hp_pos[op.handle];
        endcase
        r.head_valid = hp_count != 0;
        if (hp_count != 0) begin
            r.head_handle = hp_handle[1];
            r.head_key    = hp_key[1];
        end
        r.count = SLOT_W'(hp_count);
        return r;
    endfunction

    // ---- stimulus ----------------------------------------------------------
    // A shadow count lets the generator aim slots at live entries; the
    // predictor itself runs only at acceptance.
    int gen_count = 0;

    function automatic void push_op(logic [FUNC_W-1:0] f, logic [HANDLE_W-1:0] h,
                                    logic [KEY_W-1:0] k, logic [SLOT_W-1:0] s, logic d);
        t_op op;
        op = '{func: f, handle: h, key: k, slot: s, drain: d};
        if (f == FN_INSERT && gen_count < CAPACITY) gen_count++;
        if (f == FN_DELETE && s != 0 && s <= gen_count) gen_count--;
        pending_ops.push_back(op);
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 3))
            0: return KEY_W'($urandom_range(0, 7));    // many ties
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [SLOT_W-1:0] live_slot();
        if (gen_count == 0 || $urandom_range(0, 9) == 0)
            return SLOT_W'($urandom_range(0, 127));
        return SLOT_W'($urandom_range(1, gen_count));
    endfunction

    initial begin
        int target;
        logic [FUNC_W-1:0] f;
        // directed: empty-heap errors, extremes, duplicate handles, ties
        push_op(FN_DELETE, 8'd0, '0, 7'd1, 1'b0);
        push_op(FN_SETKEY, 8'd0, '0, 7'd0, 1'b0);
        push_op(FN_LOCATE, 8'hFF, '0, 7'd0, 1'b0);
        push_op(FN_INSERT, 8'h00, 32'h0, 7'd0, 1'b0);
        push_op(FN_INSERT, 8'hFF, 32'hFFFF_FFFF, 7'd127, 1'b0);
        push_op(FN_INSERT, 8'h55, 32'hFFFF_FFFF, 7'd0, 1'b0);
        push_op(FN_INSERT, 8'h55, 32'h5, 7'd0, 1'b0);
        push_op(FN_LOCATE, 8'h55, '0, 7'd0, 1'b0);
        push_op(FN_SETKEY, 8'h0, 32'h5, 7'd4, 1'b0);
        push_op(FN_SETKEY, 8'h0, 32'hAAAA_AAAA, 7'd4, 1'b0);
        push_op(FN_SETKEY, 8'h0, 32'h0, 7'd1, 1'b0);
        push_op(FN_SETKEY, 8'h0, '0, 7'd5, 1'b0);
        push_op(FN_DELETE, 8'h0, '0, 7'd127, 1'b0);
        push_op(FN_DELETE, 8'h0, '0, 7'd4, 1'b0);
        push_op(FN_DELETE, 8'h0, '0, 7'd1, 1'b1);
        push_op(FN_LOCATE, 8'hFF, '0, 7'd0, 1'b0);
        // fill to capacity, then overflow
        while (gen_count < CAPACITY)
            push_op(FN_INSERT, 8'($urandom), rand_key(), 7'd0, 1'b0);
        push_op(FN_INSERT, 8'hA5, 32'h1234_5678, 7'd0, 1'b1);
        push_op(FN_SETKEY, 8'h0, 32'h1, 7'd64, 1'b0);
        push_op(FN_DELETE, 8'h0, '0, 7'd64, 1'b0);
        push_op(FN_DELETE, 8'h0, '0, 7'd65, 1'b0);
        // random phases wander the fill level between empty and full
        target = 8;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 120 == 0) target = $urandom_range(0, CAPACITY);
            case ($urandom_range(0, 9))
                0, 1, 2: f = (gen_count < target) ? FN_INSERT : FN_DELETE;
                3, 4:    f = FN_INSERT;
                5, 6:    f = FN_DELETE;
                7, 8:    f = FN_SETKEY;
                default: f = FN_LOCATE;
            endcase
            push_op(f, 8'($urandom), rand_key(), live_slot(), n % 250 == 249);
        end
    end

    // ---- driver ------------------------------------------------------------
    int  rst_cycles = 0;
    int  send_gap = 0;
    bit  sent_any = 1'b0;

    always @(posedge i_clk) begin
        t_op op;
        if (rst_cycles < 3) begin
            rst_cycles <= rst_cycles + 1;
            i_rst_n    <= (rst_cycles == 2);
        end else if (i_valid && !o_stall) begin
            // beat taken: predict at acceptance, then pick the next gap
            op = pending_ops.pop_front();
            expected_res.push_back(hp_apply(op));
            i_valid  <= 1'b0;
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else if (!i_valid && pending_ops.size() != 0) begin
            if (send_gap != 0) send_gap <= send_gap - 1;
            else if (!(pending_ops[0].drain && expected_res.size() != 0)) begin
                op = pending_ops[0];
                i_func   <= op.func;
                i_handle <= op.handle;
                i_key    <= op.key;
                i_slot   <= op.slot;
                i_valid  <= 1'b1;
            end
        end
    end

    // ---- monitor -----------------------------------------------------------
    int recv_gap = 0;

    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = '{o_status, o_out_handle, o_out_key, o_out_slot,
                        o_head_valid, o_head_handle, o_head_key, o_count};
                if (expected_res.size() == 0) begin
                    $display("%0t: result beat with nothing expected: %p", $time, got);
                    failed = 1'b1;
                end else begin
                    want = expected_res.pop_front();
                    if (got != want) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        failed = 1'b1;
                    end
                end
                recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
            // stall the receiver for the drawn number of cycles
            if (recv_gap != 0) begin
                i_stall  <= 1'b1;
                recv_gap = recv_gap - 1;
            end else i_stall <= 1'b0;
        end
    end

    // ---- watchdog and end of run ------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog timeout", $time);
            $display("** indexed_max_heap_queue: FAILED **");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < HANDLES; i++) hp_pos[i] = '0;
        hp_count = 0;
        wait (i_rst_n);
        wait (pending_ops.size() == 0 && !i_valid);
        wait (expected_res.size() == 0);
        repeat (60) @(posedge i_clk);
        if (!failed && expected_res.size() == 0) begin
            $display("** indexed_max_heap_queue: PASSED **");
        end else begin
            $display("** indexed_max_heap_queue: FAILED **");
        end
        $finish;
    end

endmodule
